// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ----- hdl/ltti_pkg.sv -----
// ----------------------------------------------------------------------------
// ltti_pkg
// Types, widths and codes shared by the log temperature table interpolator.
// ----------------------------------------------------------------------------
package ltti_pkg;

    // Default number of grid points held in each table.
    localparam int TABLE_DEPTH_DEF = 512;

    // Field widths.
    localparam int LOG_W      = 20;
    localparam int INV_W      = 24;
    localparam int CNT_W      = 10;
    localparam int IDX_W      = 9;
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Arithmetic widths. CALC_W holds any grid depth up to 4096 and any bin + 1.
    localparam int PRODB_W = LOG_W + INV_W;
    localparam int BIN_W   = PRODB_W - 32;
    localparam int CALC_W  = 13;
    localparam int PM_W    = 32;
    localparam int MW_W    = PM_W + INV_W;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int PROD_W  = WGT_W + VAL_W;
    localparam int SUM_W   = PROD_W + 1;

    // One in Q.16.
    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

    // Request operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_INV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 3'd4;

    // Configuration reset values.
    localparam logic [LOG_W-1:0] LOG_MIN_RST   = 20'd0;
    localparam logic [LOG_W-1:0] LOG_MAX_RST   = 20'hFFFFF;
    localparam logic [LOG_W-1:0] BIN_STEP_RST  = 20'd6554;
    localparam logic [INV_W-1:0] BIN_INV_RST   = 24'd655360;
    localparam logic [CNT_W-1:0] BIN_COUNT_RST = 10'd512;

    // Request payload.
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] ct_value;
        logic [VAL_W-1:0] lambda_value;
        logic [VAL_W-1:0] ft_value;
        logic [LOG_W-1:0] log_temperature;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic             in_range;
        logic [VAL_W-1:0] ct_out;
        logic [VAL_W-1:0] lambda_out;
        logic [VAL_W-1:0] ft_out;
    } t_res;

    // One grid entry of all three tables.
    typedef struct packed {
        logic [VAL_W-1:0] ct;
        logic [VAL_W-1:0] lambda;
        logic [VAL_W-1:0] ft;
    } t_entry;

endpackage

// ----- hdl/ltti_tables.sv -----
// ----------------------------------------------------------------------------
// ltti_tables
// Table store: one write port and two registered read ports over all three
// calibration tables, kept side by side in one wide memory.
// ----------------------------------------------------------------------------
module ltti_tables #(
    parameter int DEPTH = ltti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  ltti_pkg::t_entry           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr_b,
    output ltti_pkg::t_entry           o_rd_data_a,
    output ltti_pkg::t_entry           o_rd_data_b
);
    import ltti_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // Write one entry and read both neighbours; read data holds while disabled.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- hdl/log_temperature_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// log_temperature_table_interpolator
// Linear interpolation of three calibration tables on a uniform grid of
// log10 temperature, with table loading through the same request stream.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  request   in         i_valid / o_stall       i_req (t_req)
//  result    out        o_valid / i_stall       o_res (t_res)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One request enters per cycle while o_stall is low. Each request passes
//  through a ten-stage pipeline, the table memory being read or written
//  on entry to stage eight. A stage holds only when it and the next one
//  are full and the next one holds too, so requests keep entering while
//  a result waits; o_stall rises only when all ten stages hold requests.
//  Reset (synchronous, active low) empties the pipeline and restores the
//  configuration; table contents are not cleared.
//
`include "assert_macros.svh"

module log_temperature_table_interpolator #(
    parameter int TABLE_DEPTH = ltti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ltti_pkg::t_req                      i_req,
    output logic                                o_valid,
    input  logic                                i_stall,
    output ltti_pkg::t_res                      o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ltti_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ltti_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ltti_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int NSTG = 10;
    localparam logic [CALC_W-1:0] DEPTH_C = CALC_W'(TABLE_DEPTH);

    // Fields that ride along with every request.
    typedef struct packed {
        logic          wr;
        logic [AW-1:0] waddr;
        t_entry        wdata;
        logic          inr;
    } t_carry;

    typedef struct packed {
        t_carry           carry;
        logic [LOG_W-1:0] d;
    } t_s2;

    typedef struct packed {
        t_carry           carry;
        logic [LOG_W-1:0] d;
        logic [BIN_W-1:0] bin;
    } t_s3;

    typedef struct packed {
        t_carry            carry;
        logic [LOG_W-1:0]  d;
        logic [AW-1:0]     i1;
        logic [AW-1:0]     i2;
        logic [CALC_W-1:0] i1p1;
    } t_s4;

    typedef struct packed {
        t_carry           carry;
        logic [LOG_W-1:0] d;
        logic [AW-1:0]    i1;
        logic [AW-1:0]    i2;
        logic [PM_W-1:0]  pm;
    } t_s5;

    typedef struct packed {
        t_carry          carry;
        logic [AW-1:0]   i1;
        logic [AW-1:0]   i2;
        logic            le;
        logic [PM_W-1:0] diff;
    } t_s6;

    typedef struct packed {
        t_carry          carry;
        logic [AW-1:0]   i1;
        logic [AW-1:0]   i2;
        logic            le;
        logic [MW_W-1:0] mw;
    } t_s7;

    typedef struct packed {
        logic             inr;
        logic [WGT_W-1:0] w1;
        logic [WGT_W-1:0] w2;
    } t_s8;

    typedef struct packed {
        logic              inr;
        logic [PROD_W-1:0] ct_a;
        logic [PROD_W-1:0] ct_b;
        logic [PROD_W-1:0] lambda_a;
        logic [PROD_W-1:0] lambda_b;
        logic [PROD_W-1:0] ft_a;
        logic [PROD_W-1:0] ft_b;
    } t_s9;

    // Configuration registers.
    logic [LOG_W-1:0]  r_log_min;
    logic [LOG_W-1:0]  r_log_max;
    logic [LOG_W-1:0]  r_bin_step;
    logic [INV_W-1:0]  r_bin_inv;
    logic [CNT_W-1:0]  r_bin_count;
    logic [CALC_W-1:0] r_last_idx;
    logic [CALC_W-1:0] n_last_idx;

    // Pipeline control.
    logic [NSTG:1]   r_v;
    logic [NSTG:1]   v_in;
    logic [NSTG+1:1] rdy;

    // Pipeline payload.
    t_req r_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4  r_s4, n_s4;
    t_s5  r_s5, n_s5;
    t_s6  r_s6, n_s6;
    t_s7  r_s7, n_s7;
    t_s8  r_s8, n_s8;
    t_s9  r_s9, n_s9;
    t_res r_res, n_res;

    // Table memory ports.
    logic   mem_wr_en;
    t_entry mem_a;
    t_entry mem_b;

    // Configuration writes; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_min   <= LOG_MIN_RST;
            r_log_max   <= LOG_MAX_RST;
            r_bin_step  <= BIN_STEP_RST;
            r_bin_inv   <= BIN_INV_RST;
            r_bin_count <= BIN_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LOG_MIN:   r_log_min   <= i_cfg_data[LOG_W-1:0];
                CFG_LOG_MAX:   r_log_max   <= i_cfg_data[LOG_W-1:0];
                CFG_BIN_STEP:  r_bin_step  <= i_cfg_data[LOG_W-1:0];
                CFG_BIN_INV:   r_bin_inv   <= i_cfg_data[INV_W-1:0];
                CFG_BIN_COUNT: r_bin_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Last usable grid index: the grid count clamped to the table depth, minus one.
    always_comb begin
        if (CALC_W'(r_bin_count) == '0) begin
            n_last_idx = '0;
        end else if (CALC_W'(r_bin_count) > DEPTH_C) begin
            n_last_idx = DEPTH_C - 1'b1;
        end else begin
            n_last_idx = CALC_W'(r_bin_count) - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        rdy[NSTG+1] = !i_stall;
        for (int k = NSTG; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign v_in    = {r_v[NSTG-1:1], i_valid};
    assign o_stall = !rdy[1];
    assign o_valid = r_v[NSTG];
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= v_in[k];
                end
            end
        end
    end

    // Range check, write decode and offset from the bottom of the grid.
    always_comb begin
        logic [CALC_W-1:0] idx_ext;
        idx_ext = CALC_W'(r_s1.entry_index);
        n_s2.carry.wr    = (r_s1.op == OP_WRITE) && (idx_ext < DEPTH_C);
        n_s2.carry.waddr = idx_ext[AW-1:0];
        n_s2.carry.wdata = '{ct: r_s1.ct_value, lambda: r_s1.lambda_value,
                             ft: r_s1.ft_value};
        n_s2.carry.inr   = (r_s1.op == OP_LOOKUP)
                           && (r_s1.log_temperature >= r_log_min)
                           && (r_s1.log_temperature <= r_log_max);
        n_s2.d           = r_s1.log_temperature - r_log_min;
    end

    // Bin number from the offset times the reciprocal step.
    always_comb begin
        logic [PRODB_W-1:0] prod;
        prod       = PRODB_W'(r_s2.d) * PRODB_W'(r_bin_inv);
        n_s3.carry = r_s2.carry;
        n_s3.d     = r_s2.d;
        n_s3.bin   = prod[PRODB_W-1:32];
    end

    // Both neighbour indices clamped to the last usable grid point.
    always_comb begin
        logic [CALC_W-1:0] bin_e;
        logic [CALC_W-1:0] bin_n;
        logic [CALC_W-1:0] i1c;
        logic [CALC_W-1:0] i2c;
        bin_e      = CALC_W'(r_s3.bin);
        bin_n      = bin_e + 1'b1;
        i1c        = (bin_e < r_last_idx) ? bin_e : r_last_idx;
        i2c        = (bin_n < r_last_idx) ? bin_n : r_last_idx;
        n_s4.carry = r_s3.carry;
        n_s4.d     = r_s3.d;
        n_s4.i1    = i1c[AW-1:0];
        n_s4.i2    = i2c[AW-1:0];
        n_s4.i1p1  = i1c + 1'b1;
    end

    // Upper grid point of the bin, measured from the bottom of the grid.
    always_comb begin
        n_s5.carry = r_s4.carry;
        n_s5.d     = r_s4.d;
        n_s5.i1    = r_s4.i1;
        n_s5.i2    = r_s4.i2;
        n_s5.pm    = PM_W'(r_bin_step) * PM_W'(r_s4.i1p1);
    end

    // Distance from the lookup point up to the upper grid point.
    always_comb begin
        n_s6.carry = r_s5.carry;
        n_s6.i1    = r_s5.i1;
        n_s6.i2    = r_s5.i2;
        n_s6.le    = r_s5.pm <= PM_W'(r_s5.d);
        n_s6.diff  = r_s5.pm - PM_W'(r_s5.d);
    end

    // Raw weight of the lower entry.
    always_comb begin
        n_s7.carry = r_s6.carry;
        n_s7.i1    = r_s6.i1;
        n_s7.i2    = r_s6.i2;
        n_s7.le    = r_s6.le;
        n_s7.mw    = MW_W'(r_s6.diff) * MW_W'(r_bin_inv);
    end

    // Weights saturated to one; the table is read or written on this move.
    always_comb begin
        logic over;
        over = (|r_s7.mw[MW_W-1:FRAC_W+WGT_W])
               || (r_s7.mw[FRAC_W+WGT_W-1:FRAC_W] > ONE_Q16);
        n_s8.inr = r_s7.carry.inr;
        if (r_s7.le) begin
            n_s8.w1 = '0;
        end else if (over) begin
            n_s8.w1 = ONE_Q16;
        end else begin
            n_s8.w1 = r_s7.mw[FRAC_W+WGT_W-1:FRAC_W];
        end
        n_s8.w2 = ONE_Q16 - n_s8.w1;
    end

    assign mem_wr_en = rdy[8] && r_v[7] && r_s7.carry.wr;

    ltti_tables #(
        .DEPTH (TABLE_DEPTH)
    ) u_tables (
        .i_clk       (i_clk),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (r_s7.carry.waddr),
        .i_wr_data   (r_s7.carry.wdata),
        .i_rd_en     (rdy[8]),
        .i_rd_addr_a (r_s7.i1),
        .i_rd_addr_b (r_s7.i2),
        .o_rd_data_a (mem_a),
        .o_rd_data_b (mem_b)
    );

    // Weighted entries, one product per table and neighbour.
    always_comb begin
        n_s9.inr      = r_s8.inr;
        n_s9.ct_a     = PROD_W'(r_s8.w1) * PROD_W'(mem_a.ct);
        n_s9.ct_b     = PROD_W'(r_s8.w2) * PROD_W'(mem_b.ct);
        n_s9.lambda_a = PROD_W'(r_s8.w1) * PROD_W'(mem_a.lambda);
        n_s9.lambda_b = PROD_W'(r_s8.w2) * PROD_W'(mem_b.lambda);
        n_s9.ft_a     = PROD_W'(r_s8.w1) * PROD_W'(mem_a.ft);
        n_s9.ft_b     = PROD_W'(r_s8.w2) * PROD_W'(mem_b.ft);
    end

    // Sum, drop the fraction, and zero everything outside the grid range.
    always_comb begin
        logic [SUM_W-1:0] s_ct;
        logic [SUM_W-1:0] s_lambda;
        logic [SUM_W-1:0] s_ft;
        s_ct     = SUM_W'(r_s9.ct_a) + SUM_W'(r_s9.ct_b);
        s_lambda = SUM_W'(r_s9.lambda_a) + SUM_W'(r_s9.lambda_b);
        s_ft     = SUM_W'(r_s9.ft_a) + SUM_W'(r_s9.ft_b);
        n_res.in_range = r_s9.inr;
        if (r_s9.inr) begin
            n_res.ct_out     = s_ct[FRAC_W+VAL_W-1:FRAC_W];
            n_res.lambda_out = s_lambda[FRAC_W+VAL_W-1:FRAC_W];
            n_res.ft_out     = s_ft[FRAC_W+VAL_W-1:FRAC_W];
        end else begin
            n_res.ct_out     = '0;
            n_res.lambda_out = '0;
            n_res.ft_out     = '0;
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1 <= i_req;
        end
        if (rdy[2]) begin
            r_s2 <= n_s2;
        end
        if (rdy[3]) begin
            r_s3 <= n_s3;
        end
        if (rdy[4]) begin
            r_s4 <= n_s4;
        end
        if (rdy[5]) begin
            r_s5 <= n_s5;
        end
        if (rdy[6]) begin
            r_s6 <= n_s6;
        end
        if (rdy[7]) begin
            r_s7 <= n_s7;
        end
        if (rdy[8]) begin
            r_s8 <= n_s8;
        end
        if (rdy[9]) begin
            r_s9 <= n_s9;
        end
        if (rdy[10]) begin
            r_res <= n_res;
        end
    end

    // Requests are held back only when every stage is occupied.
    `ASSERT_IMPLIES(a_stall_full, i_clk, i_rst_n, o_stall, &r_v, "stall with an empty stage")

    // The two weights of a lookup always add up to one.
    `ASSERT_IMPLIES(a_weight_sum, i_clk, i_rst_n, r_v[8], WGT_W'(r_s8.w1 + r_s8.w2) == ONE_Q16, "weights do not sum to one")

    // The lower weight never exceeds one.
    `ASSERT_IMPLIES(a_weight_max, i_clk, i_rst_n, r_v[8], r_s8.w1 <= ONE_Q16, "weight above one")

    // A result outside the grid range carries only zeros.
    `ASSERT_IMPLIES(a_out_zero, i_clk, i_rst_n, o_valid && !o_res.in_range, (o_res.ct_out == '0) && (o_res.lambda_out == '0) && (o_res.ft_out == '0), "nonzero result outside range")

endmodule
